>>> design/matrix3x3_inverse_macros.svh
// Assertion macros for the 3x3 matrix inverse block
`ifndef MATRIX3X3_INVERSE_MACROS_SVH
`define MATRIX3X3_INVERSE_MACROS_SVH

// Implication checked on every clock, off during reset
`define M3I_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define M3I_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/m3i_pkg.sv
// Package: widths, types and helpers for the 3x3 matrix inverse
`default_nettype none
package m3i_pkg;
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int ADJ_BITS  = PROD_BITS + 1;
    localparam int LO_BITS   = ADJ_BITS - WORD_BITS;
    localparam int TL_BITS   = WORD_BITS + LO_BITS + 1;
    localparam int DET_BITS  = ADJ_BITS + WORD_BITS + 2;
    localparam int NUM_BITS  = ADJ_BITS + 2 * FRAC_BITS;
    localparam int MAG_BITS  = NUM_BITS;
    localparam int DMAG_BITS = DET_BITS;
    localparam int LANES     = 9;
    localparam int DIV_STEPS = MAG_BITS;
    // front stages, lane input, quotient stages, saturation
    localparam int LAT       = 4 + 1 + DIV_STEPS + 1;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [ADJ_BITS-1:0]  adj_t;
    typedef logic signed [DET_BITS-1:0]  det_t;

    typedef struct packed {
        logic neg;
        logic sing;
    } lane_ctl_t;
endpackage
`default_nettype wire

>>> design/m3i_div_lane.sv
// One lane: pipelined restoring divider, one quotient bit per stage, with saturation
`default_nettype none
module m3i_div_lane
    import m3i_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [MAG_BITS-1:0]  num_mag,
    input  wire logic [DMAG_BITS-1:0] den_mag,
    input  wire lane_ctl_t            ctl,
    output word_t                     res,
    output logic                      sat
);
    localparam int RB = DMAG_BITS + 1;

    logic [MAG_BITS-1:0]  q_reg   [DIV_STEPS+1];
    logic [RB-1:0]        r_reg   [DIV_STEPS+1];
    logic [DMAG_BITS-1:0] d_reg   [DIV_STEPS+1];
    lane_ctl_t            c_reg   [DIV_STEPS+1];
    logic [RB-1:0]        sh      [DIV_STEPS];
    logic [RB:0]          diff    [DIV_STEPS];
    word_t                res_reg;
    logic                 sat_reg;

    always_comb
    begin
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            sh[s]   = {r_reg[s][RB-2:0], q_reg[s][MAG_BITS-1]};
            diff[s] = {1'b0, sh[s]} - {2'b0, d_reg[s]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg[0] <= num_mag;
            r_reg[0] <= '0;
            d_reg[0] <= den_mag;
            c_reg[0] <= ctl;
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                d_reg[s+1] <= d_reg[s];
                c_reg[s+1] <= c_reg[s];
                r_reg[s+1] <= diff[s][RB] ? sh[s] : diff[s][RB-1:0];
                q_reg[s+1] <= {q_reg[s][MAG_BITS-2:0], ~diff[s][RB]};
            end
        end
    end

    logic [MAG_BITS-1:0] q;
    logic [MAG_BITS-1:0] lim;
    logic                over;
    always_comb
    begin
        q    = q_reg[DIV_STEPS];
        lim  = {{(MAG_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}}
               + MAG_BITS'(c_reg[DIV_STEPS].neg);
        over = q > lim;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (c_reg[DIV_STEPS].sing)
            begin
                res_reg <= '0;
                sat_reg <= 1'b0;
            end
            else
            begin
                res_reg <= c_reg[DIV_STEPS].neg ? word_t'(-(over ? lim : q))
                                                : word_t'(over ? lim : q);
                sat_reg <= over;
            end
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;
endmodule
`default_nettype wire

>>> design/m3i_front.sv
// Front end: cofactor products, adjugate, determinant and magnitudes, four stages
`default_nettype none
module m3i_front
    import m3i_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire word_t                m [9],
    output logic [MAG_BITS-1:0]       num_mag [9],
    output logic [DMAG_BITS-1:0]      den_mag,
    output lane_ctl_t                 ctl [9]
);
    localparam int AI [9] = '{4,1,1,3,0,0,3,0,0};
    localparam int DI [9] = '{8,8,5,8,8,5,7,7,4};
    localparam int BI [9] = '{5,2,2,5,2,2,4,1,1};
    localparam int CI [9] = '{7,7,4,6,6,3,6,6,3};
    localparam bit FL [9] = '{0,1,0,1,0,1,0,1,0};

    logic signed [PROD_BITS-1:0] p1_reg [9];
    logic signed [PROD_BITS-1:0] p2_reg [9];
    word_t                       m_reg  [3];
    adj_t                        adj_reg [9];
    word_t                       m2_reg [3];
    logic signed [PROD_BITS-1:0] th_reg [3];
    logic signed [TL_BITS-1:0]   tl_reg [3];
    adj_t                        adj2_reg [9];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                p1_reg[i] <= PROD_BITS'(m[AI[i]]) * PROD_BITS'(m[DI[i]]);
                p2_reg[i] <= PROD_BITS'(m[BI[i]]) * PROD_BITS'(m[CI[i]]);
            end
            for (int i = 0; i < 3; i++)
                m_reg[i] <= m[i];
            for (int i = 0; i < 9; i++)
                adj_reg[i] <= FL[i] ? ADJ_BITS'(p2_reg[i]) - ADJ_BITS'(p1_reg[i])
                                    : ADJ_BITS'(p1_reg[i]) - ADJ_BITS'(p2_reg[i]);
            m2_reg   <= m_reg;
            // element times cofactor, split into high and low parts of the cofactor
            for (int i = 0; i < 3; i++)
            begin
                th_reg[i] <= PROD_BITS'(m2_reg[i])
                             * PROD_BITS'($signed(adj_reg[3*i][ADJ_BITS-1:LO_BITS]));
                tl_reg[i] <= TL_BITS'(m2_reg[i])
                             * TL_BITS'($signed({1'b0, adj_reg[3*i][LO_BITS-1:0]}));
            end
            adj2_reg <= adj_reg;
        end
    end

    // fourth stage: determinant sum and sign-magnitude split
    det_t det;
    logic dneg;
    always_comb
    begin
        det = '0;
        for (int i = 0; i < 3; i++)
            det = det + (DET_BITS'(th_reg[i]) <<< LO_BITS) + DET_BITS'(tl_reg[i]);
        dneg = det[DET_BITS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_mag <= dneg ? DMAG_BITS'(-det) : DMAG_BITS'(det);
            for (int i = 0; i < 9; i++)
            begin
                num_mag[i]  <= adj2_reg[i][ADJ_BITS-1]
                               ? {MAG_BITS'(-adj2_reg[i])} << (2 * FRAC_BITS)
                               : {MAG_BITS'(adj2_reg[i])} << (2 * FRAC_BITS);
                ctl[i].neg  <= adj2_reg[i][ADJ_BITS-1] ^ dneg;
                ctl[i].sing <= (det == '0);
            end
        end
    end
endmodule
`default_nettype wire

>>> design/matrix3x3_inverse.sv
// Top level: pipelined 3x3 fixed-point matrix inverse by adjugate
`default_nettype none
`include "matrix3x3_inverse_macros.svh"
// Fully pipelined: one matrix is taken per cycle while not stalled, and
// its result transfer follows its input transfer through the LAT stages
// (4 front stages, a lane input register, one stage per quotient bit (97)
// in each of nine divider lanes, one saturation stage). A stall on the
// output while out_valid is high freezes the whole pipeline and stalls
// the input for the same cycles; latency is set by the divider depth
// (quotient bits of the Q-scaled adjugate term).
module matrix3x3_inverse
    import m3i_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire word_t in_r0c0, in_r0c1, in_r0c2,
    input  wire word_t in_r1c0, in_r1c1, in_r1c2,
    input  wire word_t in_r2c0, in_r2c1, in_r2c2,
    output logic       out_valid,
    input  wire logic  out_stall,
    output word_t      out_r0c0, out_r0c1, out_r0c2,
    output word_t      out_r1c0, out_r1c1, out_r1c2,
    output word_t      out_r2c0, out_r2c1, out_r2c2,
    output logic       singular,
    output logic       saturated
);
    logic                en;
    logic [LAT-1:0]      vld_reg;
    word_t               m [9];
    logic [MAG_BITS-1:0] num_mag [9];
    logic [DMAG_BITS-1:0] den_mag;
    lane_ctl_t           ctl [9];
    word_t               res [9];
    logic [8:0]          sat;
    logic                sing_reg [LAT-4];

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;
    assign m = '{in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                 in_r2c0, in_r2c1, in_r2c2};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    m3i_front u_front (.clk(clk), .en(en), .m(m), .num_mag(num_mag),
                       .den_mag(den_mag), .ctl(ctl));

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        m3i_div_lane u_lane (.clk(clk), .en(en), .num_mag(num_mag[l]),
                             .den_mag(den_mag), .ctl(ctl[l]),
                             .res(res[l]), .sat(sat[l]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sing_reg[0] <= ctl[0].sing;
            for (int i = 1; i < LAT - 4; i++)
                sing_reg[i] <= sing_reg[i-1];
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign out_r0c0  = res[0];
    assign out_r0c1  = res[1];
    assign out_r0c2  = res[2];
    assign out_r1c0  = res[3];
    assign out_r1c1  = res[4];
    assign out_r1c2  = res[5];
    assign out_r2c0  = res[6];
    assign out_r2c1  = res[7];
    assign out_r2c2  = res[8];
    assign singular  = sing_reg[LAT-5];
    assign saturated = |sat;

    `M3I_ASSERT_IMP(a_sing_zero, clk, rst_n, out_valid && singular, !saturated && out_r0c0 == '0 && out_r2c2 == '0)
    `M3I_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_r1c1))
    `M3I_ASSERT_IMP(a_stall, clk, rst_n, in_stall, out_valid && out_stall)
endmodule
`default_nettype wire
